[rtl/bpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg: shared definitions for the Bezier patch point evaluator
// Defaults, fixed field widths, register indexes, status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package bpe_pkg;

    // default sizing of the top level
    localparam int MAX_SECTIONS_DEF  = 6;
    localparam int MAX_PRECISION_DEF = 30;
    localparam int COORD_BITS_DEF    = 16;

    // fixed widths of the interface fields
    localparam int GRID_IDX_W = 6;
    localparam int UV_IDX_W   = 5;
    localparam int SEC_CFG_W  = 3;
    localparam int PREC_CFG_W = 5;
    localparam int STEP_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int STATUS_W   = 2;

    // arithmetic
    localparam int GUARD_BITS   = 8;
    localparam int FRAC_BITS    = 16;
    localparam int LANES        = 3;
    localparam int MIN_SECTIONS = 3;
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(65536);

    // register reset values
    localparam logic [SEC_CFG_W-1:0]  X_SECTIONS_RST = SEC_CFG_W'(4);
    localparam logic [SEC_CFG_W-1:0]  Y_SECTIONS_RST = SEC_CFG_W'(4);
    localparam logic [PREC_CFG_W-1:0] PRECISION_RST  = PREC_CFG_W'(10);
    localparam logic [STEP_W-1:0]     STEP_RST       = STEP_W'(6554);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_SECTIONS = 2'd0,
        CFG_Y_SECTIONS = 2'd1,
        CFG_PRECISION  = 2'd2,
        CFG_STEP       = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_POINT  = 2'd0,
        STATUS_LOADED = 2'd1,
        STATUS_RANGE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEL_AB,
        SEL_BC,
        SEL_FG,
        SEL_PR
    } lerp_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD0,
        ST_LOAD1,
        ST_LOAD2,
        ST_LOAD3,
        ST_LERP_F,
        ST_LERP_G,
        ST_LERP_P,
        ST_LERP_R,
        ST_ROW_WR,
        ST_FINISH
    } state_t;

endpackage

[rtl/bpe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bpe_lerp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_lerp: three-lane fixed-point lerp
// Each lane gives sat(x + floor(((y - x) * t + half) / 2^16)) on the
// internal width.
// ----------------------------------------------------------------------------
module bpe_lerp #(
    parameter int INNER_W = 24,
    parameter int T_W     = 22
) (
    input  logic [bpe_pkg::LANES-1:0][INNER_W-1:0] x,
    input  logic [bpe_pkg::LANES-1:0][INNER_W-1:0] y,
    input  logic [T_W-1:0]                         t,
    output logic [bpe_pkg::LANES-1:0][INNER_W-1:0] res
);

    localparam int PROD_W = INNER_W + 1 + T_W + 1;
    localparam int SUM_W  = PROD_W - bpe_pkg::FRAC_BITS + 1;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (bpe_pkg::FRAC_BITS - 1);

    logic signed [INNER_W:0]    diff [bpe_pkg::LANES];
    logic signed [PROD_W-1:0]   prod [bpe_pkg::LANES];
    logic signed [PROD_W-1:0]   rnd  [bpe_pkg::LANES];
    logic signed [SUM_W-1:0]    sum  [bpe_pkg::LANES];
    logic signed [T_W:0]        t_s;

    assign t_s = $signed({1'b0, t});

    always_comb
    begin
        for (int k = 0; k < bpe_pkg::LANES; k++)
        begin
            diff[k] = (INNER_W + 1)'($signed(y[k])) - (INNER_W + 1)'($signed(x[k]));
            prod[k] = PROD_W'(diff[k]) * PROD_W'(t_s);
            rnd[k]  = prod[k] + HALF;
            sum[k]  = SUM_W'($signed(x[k])) + SUM_W'(rnd[k] >>> bpe_pkg::FRAC_BITS);
            // clip to the internal range when the upper bits disagree
            if ((&sum[k][SUM_W-1:INNER_W-1]) || !(|sum[k][SUM_W-1:INNER_W-1]))
            begin
                res[k] = sum[k][INNER_W-1:0];
            end
            else if (sum[k][SUM_W-1])
            begin
                res[k] = {1'b1, {(INNER_W - 1){1'b0}}};
            end
            else
            begin
                res[k] = {1'b0, {(INNER_W - 1){1'b1}}};
            end
        end
    end

endmodule

[rtl/bezier_patch_point_eval_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_patch_point_eval_unit: tensor-product Bezier patch evaluator
// Stores a grid of control points and evaluates surface points from grid
// indices with a shared three-lane lerp unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Item channel (item_valid/item_ready): one word is either a control point
//   load (op = 0, slot point_index, coord_x/y/z) or an evaluate request
//   (op = 1, u_index, v_index). Result channel (result_valid/result_ready):
//   exactly one word per item, point_x/y/z plus status.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//   registers only while the block is idle.
// Sequencing
//   One item is in flight at a time; item_ready is high only in idle.
//   A load goes straight to the finish state, which loads the output register
//   once it is free. An evaluate checks its indices in setup; then every
//   row and then the column of row results goes through the one lerp unit,
//   one lerp per cycle, fed by a point memory that gives one point per cycle.
//   An index out of range goes from setup straight to the finish state.
// Reset
//   Registers return to 4 x 4 sections, precision 10, step 6554. The control
//   grid is not cleared; reading a slot never loaded gives an unknown point.
// Stall
//   The result sits in an output register until taken; the next item may be
//   accepted meanwhile, and its result holds in the sequencer until the
//   output register frees up.
// ----------------------------------------------------------------------------
module bezier_patch_point_eval_unit #(
    parameter int MAX_SECTIONS  = bpe_pkg::MAX_SECTIONS_DEF,
    parameter int MAX_PRECISION = bpe_pkg::MAX_PRECISION_DEF,
    parameter int COORD_BITS    = bpe_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  op,
    input  logic [bpe_pkg::GRID_IDX_W-1:0]        point_index,
    input  logic signed [COORD_BITS-1:0]          coord_x,
    input  logic signed [COORD_BITS-1:0]          coord_y,
    input  logic signed [COORD_BITS-1:0]          coord_z,
    input  logic [bpe_pkg::UV_IDX_W-1:0]          u_index,
    input  logic [bpe_pkg::UV_IDX_W-1:0]          v_index,

    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [COORD_BITS-1:0]          point_x,
    output logic signed [COORD_BITS-1:0]          point_y,
    output logic signed [COORD_BITS-1:0]          point_z,
    output logic [bpe_pkg::STATUS_W-1:0]          status,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bpe_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int INNER_W    = COORD_BITS + bpe_pkg::GUARD_BITS;
    localparam int GRID_DEPTH = MAX_SECTIONS * MAX_SECTIONS;
    localparam int GA_W       = $clog2(GRID_DEPTH);
    localparam int IDX_W      = $clog2(MAX_SECTIONS);
    localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);
    localparam int CLAMP_W    = (CNT_W > bpe_pkg::SEC_CFG_W) ? CNT_W : bpe_pkg::SEC_CFG_W;
    localparam int PREC_W     = $clog2(MAX_PRECISION + 1);
    localparam int BND_W      = (PREC_W > bpe_pkg::PREC_CFG_W) ? PREC_W : bpe_pkg::PREC_CFG_W;
    localparam int T_W        = bpe_pkg::STEP_W + bpe_pkg::UV_IDX_W;
    localparam int LN         = bpe_pkg::LANES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bpe_pkg::SEC_CFG_W-1:0]  x_sections_reg;
    logic [bpe_pkg::SEC_CFG_W-1:0]  y_sections_reg;
    logic [bpe_pkg::PREC_CFG_W-1:0] precision_reg;
    logic [bpe_pkg::STEP_W-1:0]     step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_sections_reg <= bpe_pkg::X_SECTIONS_RST;
            y_sections_reg <= bpe_pkg::Y_SECTIONS_RST;
            precision_reg  <= bpe_pkg::PRECISION_RST;
            step_reg       <= bpe_pkg::STEP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bpe_pkg::CFG_X_SECTIONS: x_sections_reg <= cfg_data[bpe_pkg::SEC_CFG_W-1:0];
                bpe_pkg::CFG_Y_SECTIONS: y_sections_reg <= cfg_data[bpe_pkg::SEC_CFG_W-1:0];
                bpe_pkg::CFG_PRECISION:  precision_reg  <= cfg_data[bpe_pkg::PREC_CFG_W-1:0];
                bpe_pkg::CFG_STEP:       step_reg       <= cfg_data[bpe_pkg::STEP_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Derived settings, used directly: clamped section counts, index bound, step
    // User must keep config stable while the sequencer is busy; not enforced here.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]           xs_c;
    logic [CNT_W-1:0]           ys_c;
    logic [BND_W-1:0]           bound_c;
    logic [bpe_pkg::STEP_W-1:0] step_c;
    logic [CLAMP_W-1:0]         xs_ext;
    logic [CLAMP_W-1:0]         ys_ext;

    always_comb
    begin
        xs_ext = CLAMP_W'(x_sections_reg);
        ys_ext = CLAMP_W'(y_sections_reg);
        if (xs_ext < CLAMP_W'(bpe_pkg::MIN_SECTIONS))
            xs_c = CNT_W'(bpe_pkg::MIN_SECTIONS);
        else if (xs_ext > CLAMP_W'(MAX_SECTIONS))
            xs_c = CNT_W'(MAX_SECTIONS);
        else
            xs_c = CNT_W'(xs_ext);
        if (ys_ext < CLAMP_W'(bpe_pkg::MIN_SECTIONS))
            ys_c = CNT_W'(bpe_pkg::MIN_SECTIONS);
        else if (ys_ext > CLAMP_W'(MAX_SECTIONS))
            ys_c = CNT_W'(MAX_SECTIONS);
        else
            ys_c = CNT_W'(ys_ext);
        if (BND_W'(precision_reg) > BND_W'(MAX_PRECISION))
            bound_c = BND_W'(MAX_PRECISION);
        else
            bound_c = BND_W'(precision_reg);
        step_c = (step_reg > bpe_pkg::STEP_ONE) ? bpe_pkg::STEP_ONE : step_reg;
    end

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    bpe_pkg::state_t  state_reg;
    bpe_pkg::state_t  state_next;
    logic             col_phase_reg;   // 0: reducing rows, 1: reducing the column
    logic             first_reg;       // first window of the current blend
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] j_reg;           // window start of the current blend
    logic [GA_W-1:0]  base_reg;        // grid slot of the current row's first point
    logic             result_valid_reg;

    // datapath
    logic [bpe_pkg::UV_IDX_W-1:0] iu_reg;
    logic [bpe_pkg::UV_IDX_W-1:0] iv_reg;
    logic [T_W-1:0]               tu_reg;
    logic [T_W-1:0]               tv_reg;
    logic [LN-1:0][INNER_W-1:0]   a_reg;
    logic [LN-1:0][INNER_W-1:0]   b_reg;
    logic [LN-1:0][INNER_W-1:0]   c_reg;
    logic [LN-1:0][INNER_W-1:0]   nxt_reg;
    logic [LN-1:0][INNER_W-1:0]   f_reg;
    logic [LN-1:0][INNER_W-1:0]   g_reg;
    logic [LN-1:0][INNER_W-1:0]   p_reg;
    logic [LN-1:0][INNER_W-1:0]   r_reg;
    bpe_pkg::status_t             status_reg;
    logic [LN-1:0][COORD_BITS-1:0] res_reg;
    bpe_pkg::status_t             res_status_reg;

    // ------------------------------------------------------------------
    // Decoded conditions
    // ------------------------------------------------------------------
    logic accept;
    logic load_in_range;
    logic eval_out_of_range;
    logic window_last;
    logic row_last;
    logic out_free;
    logic [CNT_W-1:0] n_c;

    assign accept            = item_valid && item_ready;
    assign load_in_range     = ({1'b0, point_index} < (bpe_pkg::GRID_IDX_W + 1)'(GRID_DEPTH));
    assign eval_out_of_range = (BND_W'(iu_reg) > bound_c) || (BND_W'(iv_reg) > bound_c);
    assign window_last       = (j_reg == '0);
    assign row_last          = (row_reg == IDX_W'(ys_c - CNT_W'(1)));
    assign out_free          = !result_valid_reg || result_ready;
    assign n_c               = col_phase_reg ? ys_c : xs_c;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                if (item_valid)
                    state_next = (op == bpe_pkg::OP_EVAL) ? bpe_pkg::ST_SETUP : bpe_pkg::ST_FINISH;
            end
            bpe_pkg::ST_SETUP:
                state_next = eval_out_of_range ? bpe_pkg::ST_FINISH : bpe_pkg::ST_LOAD0;
            bpe_pkg::ST_LOAD0:  state_next = bpe_pkg::ST_LOAD1;
            bpe_pkg::ST_LOAD1:  state_next = bpe_pkg::ST_LOAD2;
            bpe_pkg::ST_LOAD2:  state_next = bpe_pkg::ST_LOAD3;
            bpe_pkg::ST_LOAD3:  state_next = bpe_pkg::ST_LERP_F;
            bpe_pkg::ST_LERP_F: state_next = bpe_pkg::ST_LERP_G;
            bpe_pkg::ST_LERP_G: state_next = bpe_pkg::ST_LERP_P;
            bpe_pkg::ST_LERP_P, bpe_pkg::ST_LERP_R:
            begin
                if ((state_reg == bpe_pkg::ST_LERP_P) && !first_reg)
                    state_next = bpe_pkg::ST_LERP_R;
                else if (!window_last)
                    state_next = bpe_pkg::ST_LERP_F;
                else if (col_phase_reg)
                    state_next = bpe_pkg::ST_FINISH;
                else
                    state_next = bpe_pkg::ST_ROW_WR;
            end
            bpe_pkg::ST_ROW_WR: state_next = bpe_pkg::ST_LOAD0;
            bpe_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = bpe_pkg::ST_IDLE;
            end
            default:            state_next = bpe_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: handshake, memory ports, lerp operand select
    // ------------------------------------------------------------------
    logic                 grid_we;
    logic                 row_we;
    logic                 out_load;
    logic [IDX_W-1:0]     rd_off;
    bpe_pkg::lerp_sel_t   lerp_sel;

    always_comb
    begin
        item_ready = 1'b0;
        grid_we    = 1'b0;
        row_we     = 1'b0;
        out_load   = 1'b0;
        rd_off     = j_reg;
        lerp_sel   = bpe_pkg::SEL_AB;
        unique case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                grid_we    = item_valid && (op == bpe_pkg::OP_LOAD) && load_in_range;
            end
            bpe_pkg::ST_LOAD0:  rd_off = j_reg + IDX_W'(2);
            bpe_pkg::ST_LOAD1:  rd_off = j_reg + IDX_W'(1);
            bpe_pkg::ST_LOAD2:  rd_off = j_reg;
            bpe_pkg::ST_LERP_F:
            begin
                // prefetch the point that opens the next window
                rd_off   = j_reg - IDX_W'(1);
                lerp_sel = bpe_pkg::SEL_AB;
            end
            bpe_pkg::ST_LERP_G: lerp_sel = bpe_pkg::SEL_BC;
            bpe_pkg::ST_LERP_P: lerp_sel = bpe_pkg::SEL_FG;
            bpe_pkg::ST_LERP_R: lerp_sel = bpe_pkg::SEL_PR;
            bpe_pkg::ST_ROW_WR: row_we   = 1'b1;
            bpe_pkg::ST_FINISH: out_load = out_free;
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Point memories
    // ------------------------------------------------------------------
    logic [LN-1:0][COORD_BITS-1:0] grid_wdata;
    logic [LN-1:0][COORD_BITS-1:0] grid_rd;
    logic [LN-1:0][INNER_W-1:0]    row_rd;
    logic [GA_W-1:0]               grid_raddr;
    logic [LN-1:0][INNER_W-1:0]    src;

    assign grid_wdata = {coord_z, coord_y, coord_x};
    assign grid_raddr = base_reg + GA_W'(rd_off);

    bpe_ram #(
        .WIDTH (LN * COORD_BITS),
        .DEPTH (GRID_DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (point_index[GA_W-1:0]),
        .wdata (grid_wdata),
        .raddr (grid_raddr),
        .rdata (grid_rd)
    );

    bpe_ram #(
        .WIDTH (LN * INNER_W),
        .DEPTH (MAX_SECTIONS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_reg),
        .wdata (r_reg),
        .raddr (rd_off),
        .rdata (row_rd)
    );

    // widen grid points to the internal range; the column pass reads row results
    always_comb
    begin
        for (int k = 0; k < LN; k++)
        begin
            src[k] = col_phase_reg ? row_rd[k] : INNER_W'($signed(grid_rd[k]));
        end
    end

    // ------------------------------------------------------------------
    // Shared lerp unit
    // ------------------------------------------------------------------
    logic [LN-1:0][INNER_W-1:0] lerp_x;
    logic [LN-1:0][INNER_W-1:0] lerp_y;
    logic [LN-1:0][INNER_W-1:0] lerp_res;
    logic [T_W-1:0]             lerp_t;

    always_comb
    begin
        unique case (lerp_sel)
            bpe_pkg::SEL_AB: begin lerp_x = a_reg; lerp_y = b_reg; end
            bpe_pkg::SEL_BC: begin lerp_x = b_reg; lerp_y = c_reg; end
            bpe_pkg::SEL_FG: begin lerp_x = f_reg; lerp_y = g_reg; end
            bpe_pkg::SEL_PR: begin lerp_x = p_reg; lerp_y = r_reg; end
            default:         begin lerp_x = a_reg; lerp_y = b_reg; end
        endcase
    end

    assign lerp_t = col_phase_reg ? tv_reg : tu_reg;

    bpe_lerp #(
        .INNER_W (INNER_W),
        .T_W     (T_W)
    ) u_lerp (
        .x   (lerp_x),
        .y   (lerp_y),
        .t   (lerp_t),
        .res (lerp_res)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic window_end;

    assign window_end = ((state_reg == bpe_pkg::ST_LERP_P) && first_reg)
                     || (state_reg == bpe_pkg::ST_LERP_R);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bpe_pkg::ST_IDLE;
            col_phase_reg    <= 1'b0;
            first_reg        <= 1'b0;
            row_reg          <= '0;
            j_reg            <= '0;
            base_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // drop valid once taken, raise it on a fresh result
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            if (state_reg == bpe_pkg::ST_SETUP)
            begin
                col_phase_reg <= 1'b0;
                first_reg     <= 1'b1;
                row_reg       <= '0;
                base_reg      <= '0;
                j_reg         <= IDX_W'(xs_c - CNT_W'(bpe_pkg::MIN_SECTIONS));
            end
            else if (state_reg == bpe_pkg::ST_ROW_WR)
            begin
                first_reg <= 1'b1;
                if (row_last)
                begin
                    col_phase_reg <= 1'b1;
                    j_reg         <= IDX_W'(ys_c - CNT_W'(bpe_pkg::MIN_SECTIONS));
                end
                else
                begin
                    row_reg  <= row_reg + IDX_W'(1);
                    base_reg <= base_reg + GA_W'(xs_c);
                    j_reg    <= IDX_W'(n_c - CNT_W'(bpe_pkg::MIN_SECTIONS));
                end
            end
            else if (window_end && !window_last)
            begin
                // advance the window one point toward the start
                first_reg <= 1'b0;
                j_reg     <= j_reg - IDX_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            bpe_pkg::ST_IDLE:
            begin
                iu_reg <= u_index;
                iv_reg <= v_index;
                status_reg <= load_in_range ? bpe_pkg::STATUS_LOADED : bpe_pkg::STATUS_RANGE;
            end
            bpe_pkg::ST_SETUP:
            begin
                tu_reg     <= T_W'(iu_reg) * T_W'(step_c);
                tv_reg     <= T_W'(iv_reg) * T_W'(step_c);
                status_reg <= eval_out_of_range ? bpe_pkg::STATUS_RANGE : bpe_pkg::STATUS_POINT;
            end
            bpe_pkg::ST_LOAD1: c_reg <= src;
            bpe_pkg::ST_LOAD2: b_reg <= src;
            bpe_pkg::ST_LOAD3: a_reg <= src;
            bpe_pkg::ST_LERP_F: f_reg <= lerp_res;
            bpe_pkg::ST_LERP_G:
            begin
                g_reg   <= lerp_res;
                nxt_reg <= src;
            end
            bpe_pkg::ST_LERP_P:
            begin
                if (first_reg)
                    r_reg <= lerp_res;
                else
                    p_reg <= lerp_res;
            end
            bpe_pkg::ST_LERP_R: r_reg <= lerp_res;
            default:
            begin
            end
        endcase

        // shift the window: the new start point comes from the prefetch
        if (window_end && !window_last)
        begin
            c_reg <= b_reg;
            b_reg <= a_reg;
            a_reg <= nxt_reg;
        end

        if (out_load)
        begin
            res_status_reg <= status_reg;
            for (int k = 0; k < LN; k++)
            begin
                if (status_reg != bpe_pkg::STATUS_POINT)
                    res_reg[k] <= '0;
                else if ((&r_reg[k][INNER_W-1:COORD_BITS-1])
                      || !(|r_reg[k][INNER_W-1:COORD_BITS-1]))
                    res_reg[k] <= r_reg[k][COORD_BITS-1:0];
                else if (r_reg[k][INNER_W-1])
                    res_reg[k] <= {1'b1, {(COORD_BITS - 1){1'b0}}};
                else
                    res_reg[k] <= {1'b0, {(COORD_BITS - 1){1'b1}}};
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign point_x      = res_reg[0];
    assign point_y      = res_reg[1];
    assign point_z      = res_reg[2];
    assign status       = res_status_reg;

endmodule

[rtl/bpe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_checker: port-level assertions for the patch evaluator
// Watches the item and result channels of the top level; bound below.
// ----------------------------------------------------------------------------
module bpe_checker #(
    parameter int COORD_BITS = bpe_pkg::COORD_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [COORD_BITS-1:0]        point_x,
    input logic [COORD_BITS-1:0]        point_y,
    input logic [COORD_BITS-1:0]        point_z,
    input logic [bpe_pkg::STATUS_W-1:0] status
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(point_x) && $stable(point_y)
            && $stable(point_z) && $stable(status))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status == bpe_pkg::STATUS_POINT
                      || status == bpe_pkg::STATUS_LOADED
                      || status == bpe_pkg::STATUS_RANGE)
        else $error("undefined status code");

    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != bpe_pkg::STATUS_POINT |->
            point_x == '0 && point_y == '0 && point_z == '0)
        else $error("non-point result carries coordinates");

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second item accepted back to back");

endmodule

bind bezier_patch_point_eval_unit bpe_checker #(.COORD_BITS(COORD_BITS)) u_bpe_checker (.*);
